FILE: design/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// Shared widths, types and helpers for the ray / triangle intersection block.
// ----------------------------------------------------------------------------
package rti_pkg;

	// field formats
	localparam int COORD_BITS = 21;
	localparam int FRAC_BITS  = 10;
	localparam int VEC_BITS   = 63;
	localparam int EPS_BITS   = 20;
	localparam int T_BITS     = 32;
	localparam int T_FRAC     = 16;

	// derived arithmetic widths
	localparam int EDGE_W  = COORD_BITS + 1;
	localparam int CROSS_W = 2 * EDGE_W + 1;
	localparam int NRM_W   = CROSS_W - FRAC_BITS;
	localparam int DOT_W   = NRM_W + EDGE_W + 2;
	localparam int TRI_W   = NRM_W + EDGE_W + 1;
	localparam int TRI_LO  = TRI_W / 2;
	localparam int TRI_HI  = TRI_W - TRI_LO;
	localparam int PART_W  = EDGE_W + TRI_HI + 1;
	localparam int SUM_W   = PART_W + 2;
	localparam int FULL_W  = SUM_W + TRI_LO + 1;
	localparam int TD_W    = T_BITS + 1 + COORD_BITS;
	localparam int PSUM_W  = TD_W - T_FRAC + 1;
	localparam int EPS_T_SHIFT = T_FRAC - FRAC_BITS;

	localparam int DIV_STEPS = T_BITS;

	// cycles for the derived geometry to follow a vertex write
	localparam int SETTLE_CYCLES = 4;
	localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);
	localparam logic [SETTLE_W-1:0] SETTLE_LOAD = SETTLE_W'(SETTLE_CYCLES);

	typedef enum logic [1:0] {
		REG_VERTEX_A = 2'd0,
		REG_VERTEX_B = 2'd1,
		REG_VERTEX_C = 2'd2,
		REG_EPSILON  = 2'd3
	} reg_idx_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [EDGE_W-1:0]     edge_t;
	typedef logic signed [NRM_W-1:0]      nrm_t;
	typedef logic signed [TRI_W-1:0]      tri_t;
	typedef logic signed [DOT_W-1:0]      dot_t;
	typedef logic [DOT_W-1:0]             mag_t;

	typedef struct packed {
		logic                miss;
		logic                sat;
		logic [VEC_BITS-1:0] origin;
		logic [VEC_BITS-1:0] direction;
	} ray_side_t;

	typedef struct packed {
		mag_t              rem;
		mag_t              ud;
		logic [T_BITS-1:0] quo;
		logic [T_BITS-1:0] bits;
		ray_side_t         side;
	} div_word_t;

	// pick one axis out of a packed vector
	function automatic coord_t unpack(input logic [VEC_BITS-1:0] w, input int idx);
		return w[idx*COORD_BITS +: COORD_BITS];
	endfunction

	// pack three axes into one word
	function automatic logic [VEC_BITS-1:0] pack(input coord_t p0, input coord_t p1,
			input coord_t p2);
		logic [VEC_BITS-1:0] r;
		r = '0;
		r[0 +: COORD_BITS]            = p0;
		r[COORD_BITS +: COORD_BITS]   = p1;
		r[2*COORD_BITS +: COORD_BITS] = p2;
		return r;
	endfunction

endpackage

FILE: design/rti_setup.sv
// ----------------------------------------------------------------------------
// rti_setup
// Derives the triangle normal and the per-edge vectors N x E from the vertex
// registers, over four register stages.
// ----------------------------------------------------------------------------
module rti_setup (
	input  logic                         clk,
	input  logic [rti_pkg::VEC_BITS-1:0] vertex_a,
	input  logic [rti_pkg::VEC_BITS-1:0] vertex_b,
	input  logic [rti_pkg::VEC_BITS-1:0] vertex_c,
	output rti_pkg::nrm_t                normal [3],
	output rti_pkg::tri_t                edge_norm [3][3]
);

	rti_pkg::coord_t va [3];
	rti_pkg::coord_t vb [3];
	rti_pkg::coord_t vc [3];
	rti_pkg::edge_t  e1 [3];
	rti_pkg::edge_t  e2 [3];
	rti_pkg::edge_t  ed [3][3];

	logic signed [2*rti_pkg::EDGE_W-1:0]           cp_q [3][2];
	rti_pkg::edge_t                                ed_q [3][3];
	logic signed [rti_pkg::CROSS_W-1:0]            ndiff [3];
	rti_pkg::nrm_t                                 nrm_q [3];
	rti_pkg::edge_t                                ed2_q [3][3];
	logic signed [rti_pkg::NRM_W+rti_pkg::EDGE_W-1:0] mp_q [3][3][2];
	rti_pkg::tri_t                                 tri_q [3][3];

	// unpack vertices, form edges
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			va[i] = rti_pkg::unpack(vertex_a, i);
			vb[i] = rti_pkg::unpack(vertex_b, i);
			vc[i] = rti_pkg::unpack(vertex_c, i);
			e1[i] = rti_pkg::edge_t'(vb[i]) - rti_pkg::edge_t'(va[i]);
			e2[i] = rti_pkg::edge_t'(vc[i]) - rti_pkg::edge_t'(va[i]);
			ed[0][i] = rti_pkg::edge_t'(vb[i]) - rti_pkg::edge_t'(va[i]);
			ed[1][i] = rti_pkg::edge_t'(vc[i]) - rti_pkg::edge_t'(vb[i]);
			ed[2][i] = rti_pkg::edge_t'(va[i]) - rti_pkg::edge_t'(vc[i]);
		end
	end

	// cross product terms of edges e1 and e2
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			cp_q[i][0] <= e1[(i == 2) ? 0 : i + 1] * e2[(i == 0) ? 2 : i - 1];
			cp_q[i][1] <= e1[(i == 0) ? 2 : i - 1] * e2[(i == 2) ? 0 : i + 1];
			for (int k = 0; k < 3; k++) begin
				ed_q[k][i] <= ed[k][i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ndiff[i] = cp_q[i][0] - cp_q[i][1];
		end
	end

	// normal rounded down to Q10
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			nrm_q[i] <= ndiff[i][rti_pkg::CROSS_W-1:rti_pkg::FRAC_BITS];
			for (int k = 0; k < 3; k++) begin
				ed2_q[k][i] <= ed_q[k][i];
			end
		end
	end

	// N x E terms per edge
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) begin
				mp_q[k][i][0] <= nrm_q[(i == 2) ? 0 : i + 1] * ed2_q[k][(i == 0) ? 2 : i - 1];
				mp_q[k][i][1] <= nrm_q[(i == 0) ? 2 : i - 1] * ed2_q[k][(i == 2) ? 0 : i + 1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) begin
				tri_q[k][i] <= mp_q[k][i][0] - mp_q[k][i][1];
			end
		end
	end

	assign normal    = nrm_q;
	assign edge_norm = tri_q;

endmodule

FILE: design/rti_div.sv
// ----------------------------------------------------------------------------
// rti_div
// Pipelined restoring divider: one quotient bit per stage, with a valid bit
// and a stall chain per stage.
// ----------------------------------------------------------------------------
module rti_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rti_pkg::div_word_t in_word,
	output logic               out_valid,
	input  logic               out_ready,
	output rti_pkg::div_word_t out_word
);

	localparam int N = rti_pkg::DIV_STEPS;

	rti_pkg::div_word_t word_s [N];
	logic [N-1:0]       vld_s;
	logic [N-1:0]       en;
	logic [N-1:0]       vld_prev;

	// a stage moves when it is empty or the next one moves
	always_comb begin
		en[N-1] = !vld_s[N-1] || out_ready;
		for (int k = N - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign vld_prev = {vld_s[N-2:0], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < N; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_prev[k];
				end
			end
		end
	end

	// one trial subtract per stage
	for (genvar k = 0; k < N; k++) begin : g_step
		rti_pkg::div_word_t           src;
		rti_pkg::div_word_t           nxt;
		logic [rti_pkg::DOT_W:0]      trial;
		logic [rti_pkg::DOT_W:0]      diff;

		if (k == 0) begin : g_first
			assign src = in_word;
		end else begin : g_next
			assign src = word_s[k-1];
		end

		assign trial = {src.rem, src.bits[rti_pkg::T_BITS-1]};
		assign diff  = trial - {1'b0, src.ud};

		always_comb begin
			nxt      = src;
			nxt.bits = {src.bits[rti_pkg::T_BITS-2:0], 1'b0};
			if (trial >= {1'b0, src.ud}) begin
				nxt.rem = diff[rti_pkg::DOT_W-1:0];
				nxt.quo = {src.quo[rti_pkg::T_BITS-2:0], 1'b1};
			end else begin
				nxt.rem = trial[rti_pkg::DOT_W-1:0];
				nxt.quo = {src.quo[rti_pkg::T_BITS-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				word_s[k] <= nxt;
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_s[N-1];
	assign out_word  = word_s[N-1];

endmodule

FILE: design/ray_triangle_intersect.sv
// Throughput: one ray per cycle while out_ready and the settle count allow it;
// the 32-stage quotient pipeline sets the depth.
// Reset clears all valid bits and loads the registers with their defaults.
// Input is held off after reset and after each register write while the normal
// and edge vectors are recomputed from the vertices.
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Geometric ray / triangle hit test in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
module ray_triangle_intersect (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [1:0]                   cfg_index,
	input  logic [rti_pkg::VEC_BITS-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rti_pkg::VEC_BITS-1:0] ray_origin,
	input  logic [rti_pkg::VEC_BITS-1:0] ray_direction,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit,
	output logic [rti_pkg::VEC_BITS-1:0] hit_point,
	output logic [rti_pkg::T_BITS-1:0]   distance
);

	// configuration
	logic [rti_pkg::VEC_BITS-1:0] vtx_a_q, vtx_b_q, vtx_c_q;
	logic [rti_pkg::EPS_BITS-1:0] eps_q;
	logic [rti_pkg::SETTLE_W-1:0] settle_q;

	rti_pkg::nrm_t   normal [3];
	rti_pkg::tri_t   edge_norm [3][3];
	rti_pkg::coord_t vtx [3][3];

	// handshake
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic en1, en2, en3, en4, en5, en6, en7, en8, en9, en10, en11, en12;
	logic accept;
	logic div_in_ready, div_out_valid;
	rti_pkg::div_word_t div_out;

	// pipeline payload
	logic [rti_pkg::VEC_BITS-1:0] o_s1, d_s1, o_s2, d_s2, o_s3, d_s3, o_s4, d_s4;
	logic [rti_pkg::VEC_BITS-1:0] o_s6, d_s6, o_s7;
	logic signed [rti_pkg::NRM_W+rti_pkg::COORD_BITS-1:0] prd_den_s2 [3];
	logic signed [rti_pkg::NRM_W+rti_pkg::EDGE_W-1:0]     prd_num_s2 [3];
	rti_pkg::dot_t den_s3, num_s3;
	rti_pkg::mag_t ud_s4, un_s4;
	logic bad_s4;
	rti_pkg::div_word_t word_s5;
	logic [rti_pkg::T_BITS-1:0] t_s6, t_s7, t_s8, t_s9, t_s10, t_s11, dist_s12;
	logic miss_s6, miss_s7, miss_s8, miss_s9, miss_s10, miss_s11, hit_s12;
	logic signed [rti_pkg::TD_W-1:0] td_s7 [3];
	rti_pkg::coord_t p_s8 [3], p_s9 [3], p_s10 [3], p_s11 [3];
	rti_pkg::edge_t dv_s9 [3][3];
	logic signed [rti_pkg::PART_W-1:0] plo_s10 [3][3], phi_s10 [3][3];
	logic signed [rti_pkg::SUM_W-1:0]  slo_s11 [3], shi_s11 [3];
	logic [rti_pkg::VEC_BITS-1:0] pos_s12;

	// combinational helpers
	rti_pkg::coord_t o_c [3], d_c [3], o7_c [3], d6_c [3];
	rti_pkg::edge_t  ao_c [3];
	rti_pkg::div_word_t word_c;
	logic [rti_pkg::T_BITS-1:0] t_c;
	logic signed [rti_pkg::PSUM_W-1:0] psum_c [3];
	rti_pkg::coord_t psat_c [3];
	logic signed [rti_pkg::FULL_W-1:0] fhi_c [3], flo_c [3], full_c [3];
	logic inside_c;

	// hold register writes; restart the settle count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx_a_q  <= '0;
			vtx_b_q  <= '0;
			vtx_c_q  <= '0;
			eps_q    <= rti_pkg::EPS_BITS'(1);
			settle_q <= rti_pkg::SETTLE_LOAD;
		end else begin
			if (cfg_write) begin
				settle_q <= rti_pkg::SETTLE_LOAD;
				unique case (rti_pkg::reg_idx_t'(cfg_index))
					rti_pkg::REG_VERTEX_A: vtx_a_q <= cfg_data;
					rti_pkg::REG_VERTEX_B: vtx_b_q <= cfg_data;
					rti_pkg::REG_VERTEX_C: vtx_c_q <= cfg_data;
					rti_pkg::REG_EPSILON:  eps_q   <= cfg_data[rti_pkg::EPS_BITS-1:0];
					default: ;
				endcase
			end else if (settle_q != '0) begin
				settle_q <= settle_q - 1'b1;
			end
		end
	end

	rti_setup u_setup (
		.clk       (clk),
		.vertex_a  (vtx_a_q),
		.vertex_b  (vtx_b_q),
		.vertex_c  (vtx_c_q),
		.normal    (normal),
		.edge_norm (edge_norm)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vtx[0][i] = rti_pkg::unpack(vtx_a_q, i);
			vtx[1][i] = rti_pkg::unpack(vtx_b_q, i);
			vtx[2][i] = rti_pkg::unpack(vtx_c_q, i);
		end
	end

	// stall chain: a stage moves when empty or when the next one moves
	assign en12 = !v_s12 || out_ready;
	assign en11 = !v_s11 || en12;
	assign en10 = !v_s10 || en11;
	assign en9  = !v_s9 || en10;
	assign en8  = !v_s8 || en9;
	assign en7  = !v_s7 || en8;
	assign en6  = !v_s6 || en7;
	assign en5  = !v_s5 || div_in_ready;
	assign en4  = !v_s4 || en5;
	assign en3  = !v_s3 || en4;
	assign en2  = !v_s2 || en3;
	assign en1  = !v_s1 || en2;

	assign in_ready = en1 && (settle_q == '0);
	assign accept   = in_valid && in_ready;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else begin
			if (en1)  v_s1  <= accept;
			if (en2)  v_s2  <= v_s1;
			if (en3)  v_s3  <= v_s2;
			if (en4)  v_s4  <= v_s3;
			if (en5)  v_s5  <= v_s4;
			if (en6)  v_s6  <= div_out_valid;
			if (en7)  v_s7  <= v_s6;
			if (en8)  v_s8  <= v_s7;
			if (en9)  v_s9  <= v_s8;
			if (en10) v_s10 <= v_s9;
			if (en11) v_s11 <= v_s10;
			if (en12) v_s12 <= v_s11;
		end
	end

	// stage 1: capture the ray word
	always_ff @(posedge clk) begin
		if (en1) begin
			o_s1 <= ray_origin;
			d_s1 <= ray_direction;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			o_c[i]  = rti_pkg::unpack(o_s1, i);
			d_c[i]  = rti_pkg::unpack(d_s1, i);
			ao_c[i] = rti_pkg::edge_t'(vtx[0][i]) - rti_pkg::edge_t'(o_c[i]);
		end
	end

	// stage 2: normal products against direction and A - O
	always_ff @(posedge clk) begin
		if (en2) begin
			o_s2 <= o_s1;
			d_s2 <= d_s1;
			for (int i = 0; i < 3; i++) begin
				prd_den_s2[i] <= normal[i] * d_c[i];
				prd_num_s2[i] <= normal[i] * ao_c[i];
			end
		end
	end

	// stage 3: dot sums
	always_ff @(posedge clk) begin
		if (en3) begin
			o_s3   <= o_s2;
			d_s3   <= d_s2;
			den_s3 <= prd_den_s2[0] + prd_den_s2[1] + prd_den_s2[2];
			num_s3 <= prd_num_s2[0] + prd_num_s2[1] + prd_num_s2[2];
		end
	end

	// stage 4: magnitudes, drop rays that hit behind the origin
	always_ff @(posedge clk) begin
		if (en4) begin
			o_s4   <= o_s3;
			d_s4   <= d_s3;
			ud_s4  <= den_s3[rti_pkg::DOT_W-1] ? -den_s3 : den_s3;
			un_s4  <= num_s3[rti_pkg::DOT_W-1] ? -num_s3 : num_s3;
			bad_s4 <= (num_s3 != '0) &&
				(num_s3[rti_pkg::DOT_W-1] != den_s3[rti_pkg::DOT_W-1]);
		end
	end

	// stage 5: parallel test, overflow test and divider seed
	always_comb begin
		word_c                = '0;
		word_c.side.origin    = o_s4;
		word_c.side.direction = d_s4;
		word_c.side.miss      = bad_s4 || (ud_s4 == '0) ||
			(ud_s4 < (rti_pkg::mag_t'(eps_q) << rti_pkg::FRAC_BITS));
		word_c.side.sat       = {{rti_pkg::T_FRAC{1'b0}}, un_s4} >=
			{ud_s4, {rti_pkg::T_FRAC{1'b0}}};
		word_c.ud             = ud_s4;
		word_c.rem            = un_s4 >> rti_pkg::T_FRAC;
		word_c.bits           = {un_s4[rti_pkg::T_FRAC-1:0],
			{(rti_pkg::T_BITS-rti_pkg::T_FRAC){1'b0}}};
		word_c.quo            = '0;
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			word_s5 <= word_c;
		end
	end

	rti_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.in_ready  (div_in_ready),
		.in_word   (word_s5),
		.out_valid (div_out_valid),
		.out_ready (en6),
		.out_word  (div_out)
	);

	// stage 6: saturate t, drop hits closer than epsilon
	assign t_c = div_out.side.sat ? '1 : div_out.quo;

	always_ff @(posedge clk) begin
		if (en6) begin
			o_s6    <= div_out.side.origin;
			d_s6    <= div_out.side.direction;
			t_s6    <= t_c;
			miss_s6 <= div_out.side.miss ||
				(t_c < (rti_pkg::T_BITS'(eps_q) << rti_pkg::EPS_T_SHIFT));
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d6_c[i] = rti_pkg::unpack(d_s6, i);
		end
	end

	// stage 7: t times direction
	always_ff @(posedge clk) begin
		if (en7) begin
			o_s7    <= o_s6;
			t_s7    <= t_s6;
			miss_s7 <= miss_s6;
			for (int i = 0; i < 3; i++) begin
				td_s7[i] <= $signed({1'b0, t_s6}) * d6_c[i];
			end
		end
	end

	// hit point, clamped to the coordinate range
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			o7_c[i]   = rti_pkg::unpack(o_s7, i);
			psum_c[i] = rti_pkg::PSUM_W'(o7_c[i] + (td_s7[i] >>> rti_pkg::T_FRAC));
			if (psum_c[i][rti_pkg::PSUM_W-1:rti_pkg::COORD_BITS-1] != '0 &&
					psum_c[i][rti_pkg::PSUM_W-1:rti_pkg::COORD_BITS-1] != '1) begin
				psat_c[i] = psum_c[i][rti_pkg::PSUM_W-1] ?
					{1'b1, {(rti_pkg::COORD_BITS-1){1'b0}}} :
					{1'b0, {(rti_pkg::COORD_BITS-1){1'b1}}};
			end else begin
				psat_c[i] = psum_c[i][rti_pkg::COORD_BITS-1:0];
			end
		end
	end

	// stage 8: hit point
	always_ff @(posedge clk) begin
		if (en8) begin
			t_s8    <= t_s7;
			miss_s8 <= miss_s7;
			p_s8    <= psat_c;
		end
	end

	// stage 9: point relative to each edge start
	always_ff @(posedge clk) begin
		if (en9) begin
			t_s9    <= t_s8;
			miss_s9 <= miss_s8;
			p_s9    <= p_s8;
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) begin
					dv_s9[k][i] <= rti_pkg::edge_t'(p_s8[i]) - rti_pkg::edge_t'(vtx[k][i]);
				end
			end
		end
	end

	// stage 10: split products against N x E
	always_ff @(posedge clk) begin
		if (en10) begin
			t_s10    <= t_s9;
			miss_s10 <= miss_s9;
			p_s10    <= p_s9;
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) begin
					plo_s10[k][i] <= dv_s9[k][i] *
						$signed({1'b0, edge_norm[k][i][rti_pkg::TRI_LO-1:0]});
					phi_s10[k][i] <= dv_s9[k][i] *
						$signed(edge_norm[k][i][rti_pkg::TRI_W-1:rti_pkg::TRI_LO]);
				end
			end
		end
	end

	// stage 11: per-edge partial sums
	always_ff @(posedge clk) begin
		if (en11) begin
			t_s11    <= t_s10;
			miss_s11 <= miss_s10;
			p_s11    <= p_s10;
			for (int k = 0; k < 3; k++) begin
				slo_s11[k] <= plo_s10[k][0] + plo_s10[k][1] + plo_s10[k][2];
				shi_s11[k] <= phi_s10[k][0] + phi_s10[k][1] + phi_s10[k][2];
			end
		end
	end

	// edge sign test: a point on an edge counts as inside
	always_comb begin
		inside_c = 1'b1;
		for (int k = 0; k < 3; k++) begin
			fhi_c[k]  = shi_s11[k];
			flo_c[k]  = slo_s11[k];
			full_c[k] = (fhi_c[k] <<< rti_pkg::TRI_LO) + flo_c[k];
			if (full_c[k][rti_pkg::FULL_W-1]) begin
				inside_c = 1'b0;
			end
		end
	end

	// stage 12: output word, zero on a miss
	always_ff @(posedge clk) begin
		if (en12) begin
			hit_s12  <= !miss_s11 && inside_c;
			pos_s12  <= (!miss_s11 && inside_c) ?
				rti_pkg::pack(p_s11[0], p_s11[1], p_s11[2]) : '0;
			dist_s12 <= (!miss_s11 && inside_c) ? t_s11 : '0;
		end
	end

	assign out_valid = v_s12;
	assign hit       = hit_s12;
	assign hit_point = pos_s12;
	assign distance  = dist_s12;

endmodule

FILE: tb/sv/ray_triangle_intersect_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_intersect_tb
// Streams rays at a configured triangle and checks the hit flag, hit point
// and distance of every result word against a fixed-point predictor.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_tb;

	typedef longint v3_t [3];
	typedef logic signed [127:0] s128_t;

	typedef struct {
		logic                         hit;
		logic [rti_pkg::VEC_BITS-1:0] pos;
		logic [rti_pkg::T_BITS-1:0]   span;
	} hit_rec_t;

	// split a packed word into sign-extended axes
	function automatic void split_vec(input logic [rti_pkg::VEC_BITS-1:0] w, output v3_t v);
		rti_pkg::coord_t c;
		for (int i = 0; i < 3; i++) begin
			c = w[i*rti_pkg::COORD_BITS +: rti_pkg::COORD_BITS];
			v[i] = c;
		end
	endfunction

	function automatic logic [rti_pkg::VEC_BITS-1:0] join_vec(input v3_t v);
		logic [rti_pkg::VEC_BITS-1:0] w;
		w = '0;
		for (int i = 0; i < 3; i++)
			w[i*rti_pkg::COORD_BITS +: rti_pkg::COORD_BITS] = v[i][rti_pkg::COORD_BITS-1:0];
		return w;
	endfunction

	class rti_scoreboard;
		logic [rti_pkg::VEC_BITS-1:0] va, vb, vc;
		logic [rti_pkg::EPS_BITS-1:0] eps;
		hit_rec_t                     expected [$];
		int errors, rays, hits, settings;

		function new();
			va = '0; vb = '0; vc = '0; eps = 1;
		endfunction

		function void set_reg(rti_pkg::reg_idx_t idx, logic [rti_pkg::VEC_BITS-1:0] val);
			case (idx)
				rti_pkg::REG_VERTEX_A: va = val;
				rti_pkg::REG_VERTEX_B: vb = val;
				rti_pkg::REG_VERTEX_C: vc = val;
				rti_pkg::REG_EPSILON:  eps = val[rti_pkg::EPS_BITS-1:0];
			endcase
		endfunction

		// true when p lies strictly right of edge v->w
		function bit right_of(v3_t n, v3_t v, v3_t w, v3_t p);
			longint e[3], q[3], cr[3];
			s128_t acc;
			for (int i = 0; i < 3; i++) begin
				e[i] = w[i] - v[i];
				q[i] = p[i] - v[i];
			end
			cr[0] = e[1] * q[2] - e[2] * q[1];
			cr[1] = e[2] * q[0] - e[0] * q[2];
			cr[2] = e[0] * q[1] - e[1] * q[0];
			acc = s128_t'(n[0]) * s128_t'(cr[0]) + s128_t'(n[1]) * s128_t'(cr[1])
				+ s128_t'(n[2]) * s128_t'(cr[2]);
			return acc < 0;
		endfunction

		function hit_rec_t predict(logic [rti_pkg::VEC_BITS-1:0] org,
				logic [rti_pkg::VEC_BITS-1:0] dir);
			v3_t a, b, c, o, d, e1, e2, n, p;
			longint den, num, v;
			logic [63:0] ud, un;
			logic [127:0] quo;
			logic [rti_pkg::T_BITS-1:0] t;
			hit_rec_t r;
			r.hit = 0; r.pos = '0; r.span = '0;
			split_vec(va, a); split_vec(vb, b); split_vec(vc, c);
			split_vec(org, o); split_vec(dir, d);
			for (int i = 0; i < 3; i++) begin
				e1[i] = b[i] - a[i];
				e2[i] = c[i] - a[i];
			end
			n[0] = e1[1] * e2[2] - e1[2] * e2[1];
			n[1] = e1[2] * e2[0] - e1[0] * e2[2];
			n[2] = e1[0] * e2[1] - e1[1] * e2[0];
			for (int i = 0; i < 3; i++) n[i] = n[i] >>> rti_pkg::FRAC_BITS;
			den = n[0] * d[0] + n[1] * d[1] + n[2] * d[2];
			num = n[0] * (a[0] - o[0]) + n[1] * (a[1] - o[1]) + n[2] * (a[2] - o[2]);
			ud = den < 0 ? -den : den;
			// drop near-parallel rays and planes behind the origin
			if (ud == 0 || ud < (64'(eps) << rti_pkg::FRAC_BITS)) return r;
			if (num != 0 && ((num < 0) != (den < 0))) return r;
			un = num < 0 ? -num : num;
			quo = ({64'd0, un} << rti_pkg::T_FRAC) / {64'd0, ud};
			t = (quo > 128'hFFFF_FFFF) ? '1 : quo[rti_pkg::T_BITS-1:0];
			if (64'(t) < (64'(eps) << rti_pkg::EPS_T_SHIFT)) return r;
			// hit point, clamped per axis
			for (int i = 0; i < 3; i++) begin
				v = o[i] + ((longint'({32'd0, t}) * d[i]) >>> rti_pkg::T_FRAC);
				if (v > (64'sd1 <<< (rti_pkg::COORD_BITS - 1)) - 1)
					v = (64'sd1 <<< (rti_pkg::COORD_BITS - 1)) - 1;
				if (v < -(64'sd1 <<< (rti_pkg::COORD_BITS - 1)))
					v = -(64'sd1 <<< (rti_pkg::COORD_BITS - 1));
				p[i] = v;
			end
			if (right_of(n, a, b, p) || right_of(n, b, c, p) || right_of(n, c, a, p))
				return r;
			r.hit = 1; r.pos = join_vec(p); r.span = t;
			return r;
		endfunction

		function void note_ray(logic [rti_pkg::VEC_BITS-1:0] org,
				logic [rti_pkg::VEC_BITS-1:0] dir);
			expected.push_back(predict(org, dir));
			rays++;
		endfunction

		function void check_result(logic h, logic [rti_pkg::VEC_BITS-1:0] pos,
				logic [rti_pkg::T_BITS-1:0] span);
			hit_rec_t e;
			if (expected.size() == 0) begin
				$display("%0t: unexpected result word hit=%0b pos=%h distance=%h",
					$time, h, pos, span);
				errors++;
				return;
			end
			e = expected.pop_front();
			if (e.hit) hits++;
			if (h !== e.hit) begin
				$display("%0t: hit expected %0b actual %0b", $time, e.hit, h);
				errors++;
			end
			if (pos !== e.pos) begin
				$display("%0t: hit_point expected %h actual %h", $time, e.pos, pos);
				errors++;
			end
			if (span !== e.span) begin
				$display("%0t: distance expected %h actual %h", $time, e.span, span);
				errors++;
			end
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n = 0;
	logic                         cfg_write = 0;
	logic [1:0]                   cfg_index = '0;
	logic [rti_pkg::VEC_BITS-1:0] cfg_data = '0;
	logic                         in_valid = 0;
	logic                         in_ready;
	logic [rti_pkg::VEC_BITS-1:0] ray_origin = '0;
	logic [rti_pkg::VEC_BITS-1:0] ray_direction = '0;
	logic                         out_valid;
	logic                         out_ready = 0;
	logic                         hit;
	logic [rti_pkg::VEC_BITS-1:0] hit_point;
	logic [rti_pkg::T_BITS-1:0]   distance;

	rti_scoreboard sb = new();
	int burst_left = 0;

	ray_triangle_intersect u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.ray_origin(ray_origin), .ray_direction(ray_direction),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .hit_point(hit_point), .distance(distance)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// hold the run to a fixed budget
	initial begin
		#3ms;
		$display("Regression FAIL");
		$finish;
	end

	// receiver: check each word, stall on a changing pattern
	initial begin
		int mode, cnt;
		mode = 0; cnt = 0;
		forever @(posedge clk) begin
			if (out_valid && out_ready) sb.check_result(hit, hit_point, distance);
			if (cnt % 64 == 0) mode = $urandom_range(0, 3);
			cnt++;
			case (mode)
				0: out_ready <= 1;
				1: out_ready <= $urandom_range(0, 1);
				2: out_ready <= (cnt % 8) < 5;
				default: out_ready <= $urandom_range(0, 7) == 0;
			endcase
		end
	end

	task automatic write_reg(rti_pkg::reg_idx_t idx, logic [rti_pkg::VEC_BITS-1:0] val);
		@(posedge clk);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.set_reg(idx, val);
		@(posedge clk);
		cfg_write <= 0;
	endtask

	// present one ray word, in bursts separated by random gaps
	task automatic send_ray(logic [rti_pkg::VEC_BITS-1:0] org,
			logic [rti_pkg::VEC_BITS-1:0] dir);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1;
		ray_origin <= org;
		ray_direction <= dir;
		do @(posedge clk); while (!in_ready);
		sb.note_ray(org, dir);
	endtask

	// lower valid and wait until every result word is back
	task automatic drain();
		int guard;
		in_valid <= 0;
		burst_left = 0;
		guard = 0;
		while (sb.expected.size() > 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
	endtask

	// ray through a point of the current triangle given by weights u,v of 256
	task automatic aimed_ray(int u, int v, int k, bit behind,
			output logic [rti_pkg::VEC_BITS-1:0] org,
			output logic [rti_pkg::VEC_BITS-1:0] dir);
		v3_t a, b, c, p, d, o;
		split_vec(sb.va, a); split_vec(sb.vb, b); split_vec(sb.vc, c);
		for (int i = 0; i < 3; i++) begin
			p[i] = a[i] + ((longint'(u) * (b[i] - a[i]) + longint'(v) * (c[i] - a[i])) >>> 8);
			d[i] = longint'($urandom_range(0, 32767)) - 16384;
			o[i] = behind ? p[i] + d[i] : p[i] - d[i];
			d[i] = d[i] >>> k;
		end
		org = join_vec(o);
		dir = join_vec(d);
	endtask

	function automatic logic [rti_pkg::VEC_BITS-1:0] rand_vec(int mag);
		v3_t v;
		for (int i = 0; i < 3; i++) v[i] = longint'($urandom_range(0, 2 * mag)) - mag;
		return join_vec(v);
	endfunction

	function automatic logic [rti_pkg::VEC_BITS-1:0] rand_word();
		return rti_pkg::VEC_BITS'({$urandom(), $urandom()});
	endfunction

	task automatic random_rays(int count);
		logic [rti_pkg::VEC_BITS-1:0] o, d;
		int u, v, sel;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			u = $urandom_range(0, 256);
			v = $urandom_range(0, 256 - u);
			if (sel < 70) aimed_ray(u, v, $urandom_range(0, 4), 0, o, d);
			else if (sel < 80) aimed_ray(u, v, $urandom_range(0, 4), 1, o, d);
			else if (sel < 90) begin
				o = rand_word();
				d = rand_word();
			end else begin
				o = rand_vec(1 << 16);
				d = rand_vec(1 << 12);
			end
			send_ray(o, d);
		end
	endtask

	task automatic load_triangle(logic [rti_pkg::VEC_BITS-1:0] a,
			logic [rti_pkg::VEC_BITS-1:0] b, logic [rti_pkg::VEC_BITS-1:0] c,
			logic [rti_pkg::EPS_BITS-1:0] e);
		logic [rti_pkg::VEC_BITS-1:0] junk;
		junk = rand_word();
		write_reg(rti_pkg::REG_VERTEX_A, a);
		write_reg(rti_pkg::REG_VERTEX_B, b);
		write_reg(rti_pkg::REG_VERTEX_C, c);
		// junk above the epsilon field must be dropped
		write_reg(rti_pkg::REG_EPSILON, {junk[rti_pkg::VEC_BITS-1:rti_pkg::EPS_BITS], e});
		sb.settings++;
	endtask

	initial begin
		logic [rti_pkg::VEC_BITS-1:0] o, d;
		v3_t t3;
		repeat (6) @(posedge clk);
		arst_n <= 1;

		// reset defaults: degenerate triangle, every ray misses
		for (int n = 0; n < 8; n++) send_ray(rand_word(), rand_word());
		drain();

		// directed rays on a plain triangle in z = 1.0
		t3 = '{0, 0, 1024};       o = join_vec(t3);
		t3 = '{8192, 0, 1024};    d = join_vec(t3);
		load_triangle(o, d, join_vec('{0, 8192, 1024}), 20'd1);
		send_ray(join_vec('{1024, 1024, 0}), join_vec('{0, 0, 1024}));        // plain hit
		send_ray(join_vec('{0, 0, 0}), join_vec('{0, 0, 1024}));              // on a vertex
		send_ray(join_vec('{4096, 0, 0}), join_vec('{0, 0, 512}));            // on an edge
		send_ray(join_vec('{4096, 4096, 0}), join_vec('{0, 0, 1024}));        // on hypotenuse
		send_ray(join_vec('{9000, 9000, 0}), join_vec('{0, 0, 1024}));        // outside
		send_ray(join_vec('{1024, 1024, 2048}), join_vec('{0, 0, 1024}));     // behind
		send_ray(join_vec('{1024, 1024, 0}), join_vec('{1024, 0, 0}));        // parallel
		send_ray(join_vec('{1024, 1024, 0}), '0);                             // zero direction
		send_ray(join_vec('{1024, 1024, 1024}), join_vec('{0, 0, 1024}));     // t of zero
		send_ray(join_vec('{1024, 1024, -1048576}), join_vec('{0, 0, 1}));    // t saturates
		send_ray(join_vec('{1024, 1024, -1048576}), join_vec('{0, 0, 16}));   // long ray
		send_ray(join_vec('{1024, 1024, 0}), join_vec('{0, 0, 1}));           // tiny den
		send_ray('1, '1);
		send_ray('0, '0);
		send_ray({3{21'h0FFFFF}}, {3{21'h100000}});
		send_ray({3{21'h100000}}, {3{21'h0FFFFF}});
		send_ray(join_vec('{1024, 1024, -1048576}), join_vec('{1048575, 0, 4096})); // clamps
		send_ray(join_vec('{1024, 1024, 2048}), join_vec('{0, 0, -1024}));    // from above
		drain();

		// random triangles and tolerances, extremes among them
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				5: load_triangle(join_vec('{-1048576, -1048576, 0}),
					join_vec('{1048575, -1048576, 0}),
					join_vec('{0, 1048575, 1048575}), 20'd0);
				6: load_triangle(rand_vec(1 << 15), rand_vec(1 << 15), rand_vec(1 << 15),
					20'hFFFFF);
				7: load_triangle(rand_vec(1 << 15), rand_vec(1 << 15), rand_vec(1 << 15),
					20'd0);
				default: load_triangle(rand_vec(1 << 15), rand_vec(1 << 15),
					rand_vec(1 << 15), rti_pkg::EPS_BITS'($urandom_range(1, 64)));
			endcase
			random_rays(250);
			drain();
		end

		$display("Sent %0d rays over %0d triangle settings; %0d of them hit.",
			sb.rays, sb.settings, sb.hits);
		if (sb.errors == 0 && sb.expected.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
